[hdl/sec_pkg.sv]
// Shared types and codes for the serial episode counter.
// Used by sec_gap_check and the top level; depends on nothing.
`timescale 1ns / 1ps

package sec_pkg;

  // Request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_LOAD_SYM = 3'd0,
    REQ_LOAD_GAP = 3'd1,
    REQ_EVENT    = 3'd2,
    REQ_READ     = 3'd3,
    REQ_RESTART  = 3'd4
  } req_e;

  // Result status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDSUP,
    ST_OUTER,
    ST_OUT_CHK,
    ST_PASS_RD,
    ST_PASS_CHK,
    ST_PREV_CHK,
    ST_SCAN,
    ST_PUSH_CHK,
    ST_PUSH_AGE,
    ST_BUMP,
    ST_WIPE
  } state_e;

  // Gap window verdict for one stored timestamp
  typedef struct packed {
    logic too_old;
    logic fits;
  } gap_flags_t;

endpackage

[hdl/sec_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port, read port returns old data on a same-cycle collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sec_gap_check.sv]
// Gap window test: signed distance from event time to a stored timestamp
// against the exclusive lower and inclusive upper bound. Uses sec_pkg.
`timescale 1ns / 1ps

module sec_gap_check #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] stored_i,
  input  logic [31:0]          lo_i,
  input  logic [31:0]          hi_i,
  output sec_pkg::gap_flags_t  flags_o
);

  localparam int unsigned CW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 2;

  logic signed [CW-1:0] delta;
  logic signed [CW-1:0] lo_s;
  logic signed [CW-1:0] hi_s;

  // distance may be negative when the stored time lies after the event
  assign delta = $signed(CW'(now_i)) - $signed(CW'(stored_i));
  assign lo_s  = $signed(CW'(lo_i));
  assign hi_s  = $signed(CW'(hi_i));

  assign flags_o.too_old = (delta > hi_s);
  assign flags_o.fits    = (delta > lo_s) && !(delta > hi_s);

endmodule

[hdl/serial_episode_counter_with_lists_top.sv]
// Top level of the serial episode counter: configuration registers, the
// sequencer and the state memories. Uses sec_pkg, sec_ram, sec_gap_check.
`timescale 1ns / 1ps

// An item is taken when start_i is high and busy_o is low; its one result
// appears for a single cycle with done_o and cannot be held off. Loads,
// unknown requests and reads of an out-of-range candidate answer in the
// cycle after the transfer; a valid support read passes through ST_RDSUP.
// Restart and, with splitting enabled, a sequence change run one pass over
// the list fill memory (restart and reset also clear support); the same
// pass follows reset, during which busy_o stays high. An event visits every
// candidate position; for every matching position it walks from the last
// position down, opens the previous list, inspects its timestamps newest
// first, pushes the event time and, on a completion, bumps support and
// wipes the lists (not for a single-symbol episode). Every step waits on
// the registered read of the symbol, gap, list fill or timestamp memory.
module serial_episode_counter_with_lists_top #(
  parameter int unsigned MAX_CANDIDATES = 64,
  parameter int unsigned MAX_LEVEL      = 8,
  parameter int unsigned LIST_DEPTH     = 16,
  parameter int unsigned TIME_BITS      = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sec_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [2:0]                       req_type_i,
  input  logic [5:0]                       cand_index_i,
  input  logic [2:0]                       position_i,
  input  logic [7:0]                       symbol_i,
  input  logic [31:0]                      start_time_i,
  input  logic [31:0]                      end_time_i,
  input  logic [15:0]                      sequence_id_i,
  input  logic [31:0]                      gap_low_i,
  input  logic [31:0]                      gap_high_i,
  output logic                             done_o,
  output logic [31:0]                      support_count_o,
  output logic [9:0]                       completions_o,
  output logic [1:0]                       status_o
);

  localparam int unsigned SLOTS  = MAX_CANDIDATES * MAX_LEVEL;
  localparam int unsigned TDEPTH = SLOTS * LIST_DEPTH;
  localparam int unsigned SAW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int unsigned CAW    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned LAW    = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
  localparam int unsigned KAW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FW     = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CCW    = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned LENW   = $clog2(MAX_LEVEL + 1);
  localparam int unsigned TB     = TIME_BITS;

  // configuration registers
  logic [3:0] ep_len_q;
  logic [6:0] cand_cnt_q;
  logic       store_end_q;
  logic       split_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_len_q    <= 4'd1;
      cand_cnt_q  <= 7'd0;
      store_end_q <= 1'b0;
      split_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sec_pkg::CFG_LEN:   ep_len_q    <= cfg_wdata_i[3:0];
        sec_pkg::CFG_COUNT: cand_cnt_q  <= cfg_wdata_i;
        sec_pkg::CFG_END:   store_end_q <= cfg_wdata_i[0];
        sec_pkg::CFG_SPLIT: split_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [LENW-1:0] len_eff;
  logic [LAW-1:0]  lm1;
  logic [CCW-1:0]  n_eff;

  always_comb begin
    if (ep_len_q == 4'd0) begin
      len_eff = LENW'(1);
    end else if (32'(ep_len_q) > MAX_LEVEL) begin
      len_eff = LENW'(MAX_LEVEL);
    end else begin
      len_eff = LENW'(ep_len_q);
    end
    if (32'(cand_cnt_q) > MAX_CANDIDATES) begin
      n_eff = CCW'(MAX_CANDIDATES);
    end else begin
      n_eff = CCW'(cand_cnt_q);
    end
  end
  assign lm1 = LAW'(len_eff - LENW'(1));

  // sequencer registers
  sec_pkg::state_e state_q, state_d;
  logic            done_q, done_d;
  logic            seen_q, seen_d;
  logic [15:0]     last_seq_q, last_seq_d;
  logic [SAW-1:0]  clr_q, clr_d;
  logic            clr_sup_q, clr_sup_d;
  logic            clr_ev_q, clr_ev_d;
  logic            clr_res_q, clr_res_d;

  logic [CCW-1:0]  c_q, c_d;
  logic [LAW-1:0]  p_q, p_d;
  logic [LAW-1:0]  s_q, s_d;
  logic [KAW-1:0]  k_q, k_d;
  logic [FW-1:0]   f_q, f_d;
  logic            first_q, first_d;
  logic [31:0]     lo_q, lo_d;
  logic [31:0]     hi_q, hi_d;
  logic [9:0]      comp_q, comp_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      sym_q, sym_d;
  logic [TB-1:0]   now_q, now_d;
  logic [TB-1:0]   rec_q, rec_d;
  logic [SAW-1:0]  slot_q, slot_d;
  logic [TAW-1:0]  tbase_q, tbase_d;
  logic [31:0]     sup_out_q, sup_out_d;
  logic [9:0]      comp_out_q, comp_out_d;
  logic [1:0]      stat_q, stat_d;

  // memory ports
  logic [SAW-1:0]    sym_raddr, sym_waddr;
  logic              sym_we;
  logic [7:0]        sym_wdata, sym_rdata;
  logic [SAW-1:0]    gap_raddr, gap_waddr;
  logic              gap_we;
  logic [63:0]       gap_wdata, gap_rdata;
  logic [TAW-1:0]    time_raddr, time_waddr;
  logic              time_we;
  logic [TB-1:0]     time_wdata, time_rdata;
  logic [SAW-1:0]    fill_raddr, fill_waddr;
  logic              fill_we;
  logic [FW-1:0]     fill_wdata, fill_rdata;
  logic [CAW-1:0]    sup_raddr, sup_waddr;
  logic              sup_we;
  logic [31:0]       sup_wdata, sup_rdata;

  sec_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_sym_ram (
    .clk_i(clk_i), .we_i(sym_we), .waddr_i(sym_waddr), .wdata_i(sym_wdata),
    .raddr_i(sym_raddr), .rdata_o(sym_rdata)
  );

  sec_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_gap_ram (
    .clk_i(clk_i), .we_i(gap_we), .waddr_i(gap_waddr), .wdata_i(gap_wdata),
    .raddr_i(gap_raddr), .rdata_o(gap_rdata)
  );

  sec_ram #(.WIDTH(TB), .DEPTH(TDEPTH)) u_time_ram (
    .clk_i(clk_i), .we_i(time_we), .waddr_i(time_waddr), .wdata_i(time_wdata),
    .raddr_i(time_raddr), .rdata_o(time_rdata)
  );

  sec_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_fill_ram (
    .clk_i(clk_i), .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(fill_raddr), .rdata_o(fill_rdata)
  );

  sec_ram #(.WIDTH(32), .DEPTH(MAX_CANDIDATES)) u_sup_ram (
    .clk_i(clk_i), .we_i(sup_we), .waddr_i(sup_waddr), .wdata_i(sup_wdata),
    .raddr_i(sup_raddr), .rdata_o(sup_rdata)
  );

  // gap test on the timestamp just read
  sec_pkg::gap_flags_t gflags;

  sec_gap_check #(.TIME_BITS(TB)) u_gap_check (
    .now_i(now_q), .stored_i(time_rdata), .lo_i(lo_q), .hi_i(hi_q),
    .flags_o(gflags)
  );

  // slot addresses of the current candidate
  logic [CAW-1:0] c_idx;
  logic [SAW-1:0] base_w, slot_cp, slot_cs, slot_pv;
  logic           ci_ok, pos_ok, gpos_ok;
  logic [SAW-1:0] load_slot;

  assign c_idx   = CAW'(c_q);
  assign base_w  = SAW'(32'(c_idx) * MAX_LEVEL);
  assign slot_cp = base_w + SAW'(p_q);
  assign slot_cs = base_w + SAW'(s_q);
  assign slot_pv = slot_cs - SAW'(1);

  assign ci_ok     = (32'(cand_index_i) < MAX_CANDIDATES);
  assign pos_ok    = (32'(position_i) < MAX_LEVEL);
  assign gpos_ok   = (32'(position_i) + 32'd1 < MAX_LEVEL);
  assign load_slot = SAW'(32'(cand_index_i) * MAX_LEVEL + 32'(position_i));

  // next state, datapath and memory control
  always_comb begin
    logic step_s;
    logic step_p;
    step_s = 1'b0;
    step_p = 1'b0;

    state_d    = state_q;
    done_d     = 1'b0;
    seen_d     = seen_q;
    last_seq_d = last_seq_q;
    clr_d      = clr_q;
    clr_sup_d  = clr_sup_q;
    clr_ev_d   = clr_ev_q;
    clr_res_d  = clr_res_q;
    c_d        = c_q;
    p_d        = p_q;
    s_d        = s_q;
    k_d        = k_q;
    f_d        = f_q;
    first_d    = first_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    comp_d     = comp_q;
    ovf_d      = ovf_q;
    sym_d      = sym_q;
    now_d      = now_q;
    rec_d      = rec_q;
    slot_d     = slot_q;
    tbase_d    = tbase_q;
    sup_out_d  = sup_out_q;
    comp_out_d = comp_out_q;
    stat_d     = stat_q;

    sym_we     = 1'b0;
    sym_waddr  = load_slot;
    sym_wdata  = symbol_i;
    sym_raddr  = slot_cp;
    gap_we     = 1'b0;
    gap_waddr  = load_slot;
    gap_wdata  = {gap_high_i, gap_low_i};
    gap_raddr  = slot_cs;
    time_we    = 1'b0;
    time_waddr = tbase_q;
    time_wdata = rec_q;
    time_raddr = tbase_q;
    fill_we    = 1'b0;
    fill_waddr = slot_q;
    fill_wdata = '0;
    fill_raddr = slot_cs;
    sup_we     = 1'b0;
    sup_waddr  = c_idx;
    sup_wdata  = '0;
    sup_raddr  = c_idx;

    case (state_q)
      // wipe list fills (and, after reset or restart, support) one entry a cycle
      sec_pkg::ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        if (clr_sup_q && (32'(clr_q) < MAX_CANDIDATES)) begin
          sup_we    = 1'b1;
          sup_waddr = CAW'(clr_q);
        end
        clr_d = clr_q + SAW'(1);
        if (32'(clr_q) == SLOTS - 1) begin
          clr_d = '0;
          if (clr_ev_q) begin
            state_d = sec_pkg::ST_OUTER;
          end else begin
            state_d = sec_pkg::ST_IDLE;
            if (clr_res_q) begin
              done_d     = 1'b1;
              sup_out_d  = '0;
              comp_out_d = '0;
              stat_d     = sec_pkg::STAT_OK;
            end
          end
        end
      end

      sec_pkg::ST_IDLE: begin
        if (start_i) begin
          sup_out_d  = '0;
          comp_out_d = '0;
          stat_d     = sec_pkg::STAT_OK;
          case (sec_pkg::req_e'(req_type_i))
            sec_pkg::REQ_LOAD_SYM: begin
              done_d = 1'b1;
              if (ci_ok && pos_ok) begin
                sym_we = 1'b1;
              end else begin
                stat_d = sec_pkg::STAT_BAD;
              end
            end
            sec_pkg::REQ_LOAD_GAP: begin
              done_d = 1'b1;
              if (ci_ok && gpos_ok) begin
                gap_we = 1'b1;
              end else begin
                stat_d = sec_pkg::STAT_BAD;
              end
            end
            sec_pkg::REQ_EVENT: begin
              now_d      = TB'(start_time_i);
              rec_d      = store_end_q ? TB'(end_time_i) : TB'(start_time_i);
              sym_d      = symbol_i;
              comp_d     = '0;
              ovf_d      = 1'b0;
              c_d        = '0;
              p_d        = '0;
              last_seq_d = sequence_id_i;
              seen_d     = 1'b1;
              if (split_en_q && seen_q && (sequence_id_i != last_seq_q)) begin
                state_d   = sec_pkg::ST_CLEAR;
                clr_d     = '0;
                clr_sup_d = 1'b0;
                clr_ev_d  = 1'b1;
                clr_res_d = 1'b0;
              end else begin
                state_d = sec_pkg::ST_OUTER;
              end
            end
            sec_pkg::REQ_READ: begin
              if (ci_ok) begin
                sup_raddr = CAW'(cand_index_i);
                state_d   = sec_pkg::ST_RDSUP;
              end else begin
                done_d = 1'b1;
                stat_d = sec_pkg::STAT_BAD;
              end
            end
            sec_pkg::REQ_RESTART: begin
              seen_d    = 1'b0;
              state_d   = sec_pkg::ST_CLEAR;
              clr_d     = '0;
              clr_sup_d = 1'b1;
              clr_ev_d  = 1'b0;
              clr_res_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
              stat_d = sec_pkg::STAT_BAD;
            end
          endcase
        end
      end

      sec_pkg::ST_RDSUP: begin
        done_d    = 1'b1;
        sup_out_d = sup_rdata;
        state_d   = sec_pkg::ST_IDLE;
      end

      // walk candidates and positions looking for the event symbol
      sec_pkg::ST_OUTER: begin
        if (32'(c_q) >= 32'(n_eff)) begin
          done_d     = 1'b1;
          sup_out_d  = '0;
          comp_out_d = comp_q;
          stat_d     = ovf_q ? sec_pkg::STAT_OVF : sec_pkg::STAT_OK;
          state_d    = sec_pkg::ST_IDLE;
        end else begin
          sym_raddr = slot_cp;
          state_d   = sec_pkg::ST_OUT_CHK;
        end
      end

      sec_pkg::ST_OUT_CHK: begin
        if (sym_rdata == sym_q) begin
          s_d     = lm1;
          state_d = sec_pkg::ST_PASS_RD;
        end else begin
          step_p = 1'b1;
        end
      end

      // one pass: positions from last to first
      sec_pkg::ST_PASS_RD: begin
        sym_raddr = slot_cs;
        state_d   = sec_pkg::ST_PASS_CHK;
      end

      sec_pkg::ST_PASS_CHK: begin
        if (sym_rdata != sym_q) begin
          step_s = 1'b1;
        end else if (s_q == '0) begin
          if (len_eff == LENW'(1)) begin
            sup_raddr = c_idx;
            state_d   = sec_pkg::ST_BUMP;
          end else begin
            fill_raddr = slot_cs;
            gap_raddr  = slot_cs;
            slot_d     = slot_cs;
            tbase_d    = TAW'(32'(slot_cs) * LIST_DEPTH);
            state_d    = sec_pkg::ST_PUSH_CHK;
          end
        end else begin
          fill_raddr = slot_pv;
          gap_raddr  = slot_pv;
          slot_d     = slot_pv;
          tbase_d    = TAW'(32'(slot_pv) * LIST_DEPTH);
          state_d    = sec_pkg::ST_PREV_CHK;
        end
      end

      // previous list opened: fetch its newest timestamp
      sec_pkg::ST_PREV_CHK: begin
        lo_d = gap_rdata[31:0];
        hi_d = gap_rdata[63:32];
        if (fill_rdata == '0) begin
          step_s = 1'b1;
        end else begin
          time_raddr = tbase_q + TAW'(fill_rdata - FW'(1));
          k_d        = KAW'(fill_rdata - FW'(1));
          first_d    = 1'b1;
          state_d    = sec_pkg::ST_SCAN;
        end
      end

      // newest-first search for a timestamp inside the gap window; a newest entry that is too old empties the list
      sec_pkg::ST_SCAN: begin
        if (first_q && gflags.too_old) begin
          fill_we    = 1'b1;
          fill_waddr = slot_q;
          step_s     = 1'b1;
        end else if (gflags.fits) begin
          if (s_q == lm1) begin
            sup_raddr = c_idx;
            state_d   = sec_pkg::ST_BUMP;
          end else begin
            fill_raddr = slot_cs;
            gap_raddr  = slot_cs;
            slot_d     = slot_cs;
            tbase_d    = TAW'(32'(slot_cs) * LIST_DEPTH);
            state_d    = sec_pkg::ST_PUSH_CHK;
          end
        end else if (k_q == '0) begin
          step_s = 1'b1;
        end else begin
          k_d        = k_q - KAW'(1);
          time_raddr = tbase_q + TAW'(k_q - KAW'(1));
          first_d    = 1'b0;
        end
      end

      // push the event time onto the current position's list (a stale list restarts; a full one sets overflow)
      sec_pkg::ST_PUSH_CHK: begin
        hi_d = gap_rdata[63:32];
        if (fill_rdata == '0) begin
          time_we    = 1'b1;
          time_waddr = tbase_q;
          fill_we    = 1'b1;
          fill_waddr = slot_q;
          fill_wdata = FW'(1);
          step_s     = 1'b1;
        end else begin
          time_raddr = tbase_q + TAW'(fill_rdata - FW'(1));
          f_d        = fill_rdata;
          state_d    = sec_pkg::ST_PUSH_AGE;
        end
      end

      sec_pkg::ST_PUSH_AGE: begin
        if (gflags.too_old) begin
          time_we    = 1'b1;
          time_waddr = tbase_q;
          fill_we    = 1'b1;
          fill_waddr = slot_q;
          fill_wdata = FW'(1);
        end else if (32'(f_q) >= LIST_DEPTH) begin
          ovf_d = 1'b1;
        end else begin
          time_we    = 1'b1;
          time_waddr = tbase_q + TAW'(f_q);
          fill_we    = 1'b1;
          fill_waddr = slot_q;
          fill_wdata = FW'(f_q + FW'(1));
        end
        step_s = 1'b1;
      end

      // completion: saturating support bump, then wipe the lists
      sec_pkg::ST_BUMP: begin
        sup_we    = 1'b1;
        sup_waddr = c_idx;
        sup_wdata = (sup_rdata == 32'hFFFF_FFFF) ? sup_rdata : sup_rdata + 32'd1;
        comp_d    = comp_q + 10'd1;
        s_d       = '0;
        // a single-symbol episode keeps its lists untouched
        if (len_eff == LENW'(1)) begin
          step_p = 1'b1;
        end else begin
          state_d = sec_pkg::ST_WIPE;
        end
      end

      sec_pkg::ST_WIPE: begin
        fill_we    = 1'b1;
        fill_waddr = slot_cs;
        if (s_q == lm1) begin
          step_p = 1'b1;
        end else begin
          s_d = s_q + LAW'(1);
        end
      end

      default: begin
        state_d = sec_pkg::ST_IDLE;
      end
    endcase

    // next position of the pass, or end of pass
    if (step_s) begin
      if (s_q == '0) begin
        step_p = 1'b1;
      end else begin
        s_d     = s_q - LAW'(1);
        state_d = sec_pkg::ST_PASS_RD;
      end
    end

    // next candidate position
    if (step_p) begin
      state_d = sec_pkg::ST_OUTER;
      if (p_q == lm1) begin
        p_d = '0;
        c_d = c_q + CCW'(1);
      end else begin
        p_d = p_q + LAW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sec_pkg::ST_CLEAR;
      done_q     <= 1'b0;
      seen_q     <= 1'b0;
      last_seq_q <= '0;
      clr_q      <= '0;
      clr_sup_q  <= 1'b1;
      clr_ev_q   <= 1'b0;
      clr_res_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      seen_q     <= seen_d;
      last_seq_q <= last_seq_d;
      clr_q      <= clr_d;
      clr_sup_q  <= clr_sup_d;
      clr_ev_q   <= clr_ev_d;
      clr_res_q  <= clr_res_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    p_q        <= p_d;
    s_q        <= s_d;
    k_q        <= k_d;
    f_q        <= f_d;
    first_q    <= first_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    comp_q     <= comp_d;
    ovf_q      <= ovf_d;
    sym_q      <= sym_d;
    now_q      <= now_d;
    rec_q      <= rec_d;
    slot_q     <= slot_d;
    tbase_q    <= tbase_d;
    sup_out_q  <= sup_out_d;
    comp_out_q <= comp_out_d;
    stat_q     <= stat_d;
  end

  assign busy_o          = (state_q != sec_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign support_count_o = sup_out_q;
  assign completions_o   = comp_out_q;
  assign status_o        = stat_q;

  // checks
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_type_i == sec_pkg::REQ_LOAD_SYM ||
      req_type_i == sec_pkg::REQ_LOAD_GAP) |=> done_o)
    else $error("load transfer without result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == sec_pkg::STAT_OK || status_o == sec_pkg::STAT_OVF ||
      status_o == sec_pkg::STAT_BAD))
    else $error("undefined status code");

  a_ovf_no_support: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == sec_pkg::STAT_OVF |-> support_count_o == '0)
    else $error("overflow result carries support");

  a_comp_not_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && completions_o != '0 |-> status_o != sec_pkg::STAT_BAD)
    else $error("completions on a rejected request");

endmodule
